// File: sv/lps_pkg.sv
package lps_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int SAMPLE_BITS = 32;
	localparam int MAX_HEIGHT  = 4096;
	localparam int MIN_DIM     = 3;
	localparam int MARGIN_MIN  = 1;
	localparam int MARGIN_MAX  = 2;

	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int WID_W  = $clog2(MAX_WIDTH + 1);
	localparam int HGT_W  = 13;
	localparam int COL_W  = 10;
	localparam int ROW_W  = 12;
	localparam int OUT_W  = 32;
	localparam int FRAC_W = 16;
	localparam int INV_W  = 32;
	localparam int DIG_W  = 8;
	localparam int N_CELLS = INV_W / DIG_W;

	localparam int GW_FIELD_W = 11;
	localparam int GH_FIELD_W = 13;
	localparam int MG_FIELD_W = 2;

	localparam int CENTRE_GAIN = 4;
	localparam int S_W = SAMPLE_BITS + 4;
	localparam int P_W = S_W + INV_W;

	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = ((COL_W + ROW_W + OUT_W + 7) / 8) * 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	localparam int W_RST      = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam int H_RST      = 1024;
	localparam int MARGIN_RST = 1;
	localparam int INV_RST    = 65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_WIDTH    = 3'd0,
		REG_GRID_HEIGHT   = 3'd1,
		REG_RIGHT_MARGIN  = 3'd2,
		REG_BOTTOM_MARGIN = 3'd3,
		REG_INV_H_SQ      = 3'd4
	} lps_reg_t;

	typedef struct packed {
		logic [WID_W-1:0] width;
		logic [HGT_W-1:0] height;
		logic [1:0]       right_margin;
		logic [1:0]       bottom_margin;
	} lps_geom_t;

	typedef struct packed {
		logic             valid;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} lps_tag_t;

endpackage

// File: sv/lps_window.sv
module lps_window (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic signed [lps_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                   grid_start,
	input  lps_pkg::lps_geom_t                     geom,
	output logic signed [lps_pkg::S_W-1:0]         sum_s2,
	output lps_pkg::lps_tag_t                      tag_s2
);

	logic [lps_pkg::ADDR_W-1:0] col_q, c_eff, ra1, c_s1;
	logic [lps_pkg::ROW_W-1:0]  row_q, r_eff, row_s1;
	logic [lps_pkg::WID_W-1:0]  c_nxt, col_hi;
	logic [lps_pkg::HGT_W-1:0]  r_nxt, row_hi;
	logic                       col_wrap, interior, acc, wr_en;
	logic                       v_s1, int_s1, hit_c_q, hit_right_q;
	logic                       valid_s2;
	logic [lps_pkg::COL_W-1:0]  col_s2;
	logic [lps_pkg::ROW_W-1:0]  row_s2;

	logic signed [lps_pkg::SAMPLE_BITS-1:0] x_s1, rd_mid_q, rd_right_q, rd_up_q;
	logic signed [lps_pkg::SAMPLE_BITS-1:0] wx_q, wm_q, prev_mid_q, mid, right, up;

	logic signed [lps_pkg::SAMPLE_BITS-1:0] centre_mem [lps_pkg::MAX_WIDTH];
	logic signed [lps_pkg::SAMPLE_BITS-1:0] above_mem  [lps_pkg::MAX_WIDTH];

	assign acc   = in_valid & en;
	assign wr_en = en & v_s1;

	always_comb begin
		c_eff = (grid_start || (lps_pkg::WID_W'(col_q) >= geom.width)) ? '0 : col_q;
		r_eff = (grid_start || (lps_pkg::HGT_W'(row_q) >= geom.height)) ? '0 : row_q;
		c_nxt = lps_pkg::WID_W'(c_eff) + lps_pkg::WID_W'(1);
		r_nxt = lps_pkg::HGT_W'(r_eff) + lps_pkg::HGT_W'(1);
		col_wrap = c_nxt >= geom.width;
		col_hi = geom.width - lps_pkg::WID_W'(1) - lps_pkg::WID_W'(geom.right_margin);
		row_hi = geom.height - lps_pkg::HGT_W'(geom.bottom_margin);
		interior = (r_eff >= lps_pkg::ROW_W'(2)) && (c_eff != '0)
			&& (lps_pkg::WID_W'(c_eff) <= col_hi) && (lps_pkg::HGT_W'(r_eff) <= row_hi);
		ra1 = c_eff + lps_pkg::ADDR_W'(1);
	end

	assign mid   = hit_c_q ? wx_q : rd_mid_q;
	assign right = hit_right_q ? wx_q : rd_right_q;
	assign up    = hit_c_q ? wm_q : rd_up_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			v_s1     <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (acc) begin
				col_q <= col_wrap ? '0 : lps_pkg::ADDR_W'(c_nxt);
				if (col_wrap) begin
					row_q <= (r_nxt >= geom.height) ? '0 : lps_pkg::ROW_W'(r_nxt);
				end else begin
					row_q <= r_eff;
				end
			end
			if (en) begin
				v_s1     <= in_valid;
				valid_s2 <= v_s1 & int_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			centre_mem[c_s1] <= x_s1;
			above_mem[c_s1]  <= mid;
		end
		if (acc) begin
			rd_mid_q   <= centre_mem[c_eff];
			rd_right_q <= centre_mem[ra1];
			rd_up_q    <= above_mem[c_eff];
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			x_s1        <= sample;
			c_s1        <= c_eff;
			row_s1      <= r_eff - lps_pkg::ROW_W'(1);
			int_s1      <= interior;
			hit_c_q     <= wr_en && (c_s1 == c_eff);
			hit_right_q <= wr_en && (c_s1 == ra1);
			wx_q        <= x_s1;
			wm_q        <= mid;
		end
		if (wr_en) begin
			prev_mid_q <= mid;
		end
		if (en) begin
			sum_s2 <= lps_pkg::S_W'(up) + lps_pkg::S_W'(x_s1) + lps_pkg::S_W'(prev_mid_q)
				+ lps_pkg::S_W'(right)
				- lps_pkg::S_W'(mid) * lps_pkg::S_W'(lps_pkg::CENTRE_GAIN);
			col_s2 <= lps_pkg::COL_W'(c_s1);
			row_s2 <= row_s1;
		end
	end

	assign tag_s2 = '{valid: valid_s2, col: col_s2, row: row_s2};

endmodule

// File: sv/lps_mac_cell.sv
module lps_mac_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic [lps_pkg::DIG_W-1:0]       digit,
	input  logic signed [lps_pkg::S_W-1:0]  sum_in,
	input  logic signed [lps_pkg::P_W-1:0]  acc_in,
	input  lps_pkg::lps_tag_t               tag_in,
	output logic signed [lps_pkg::S_W-1:0]  sum_out,
	output logic signed [lps_pkg::P_W-1:0]  acc_out,
	output lps_pkg::lps_tag_t               tag_out
);

	logic signed [lps_pkg::S_W+lps_pkg::DIG_W:0] prod;
	logic signed [lps_pkg::S_W-1:0]              sum_s1;
	logic signed [lps_pkg::P_W-1:0]              acc_s1;
	logic                                        valid_s1;
	logic [lps_pkg::COL_W-1:0]                   col_s1;
	logic [lps_pkg::ROW_W-1:0]                   row_s1;

	assign prod = sum_in * $signed({1'b0, digit});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= tag_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= sum_in;
			acc_s1 <= (acc_in <<< lps_pkg::DIG_W) + lps_pkg::P_W'(prod);
			col_s1 <= tag_in.col;
			row_s1 <= tag_in.row;
		end
	end

	assign sum_out = sum_s1;
	assign acc_out = acc_s1;
	assign tag_out = '{valid: valid_s1, col: col_s1, row: row_s1};

endmodule

// File: sv/five_point_laplacian_stencil.sv
// Channel   Handshake                    Payload
// s_axis    s_axis_tvalid/s_axis_tready  tdata: sample; tuser: grid_start
// m_axis    m_axis_tvalid/m_axis_tready  tdata: col_index, row_index, laplacian_value;
//                                        tuser: saturated
// cfg       cfg_valid/cfg_ready          cfg_index, cfg_data
//
// One sample per cycle unless the pipeline halts; between its sample and the output
// register a result passes one line-store read, one adder stage, four multiply cells.
// The whole pipeline advances together and halts only when the output register
// and its skid entry both hold results; s_axis_tready comes from flops.
// Reset restores the register defaults and clears counters and valids; the
// line stores hold nothing useful until a grid has streamed through.
module five_point_laplacian_stencil (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [lps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [31:0] sample
	input  logic                               s_axis_tuser,  // [0] grid_start
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [lps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // col_index, row_index, laplacian_value
	output logic                               m_axis_tuser,  // [0] saturated
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lps_pkg::CFG_DATA_W-1:0]     cfg_data
);

	typedef struct packed {
		logic                        saturated;
		logic [lps_pkg::OUT_W-1:0]   value;
		logic [lps_pkg::ROW_W-1:0]   row;
		logic [lps_pkg::COL_W-1:0]   col;
	} result_t;

	localparam int HI_W = lps_pkg::P_W - lps_pkg::FRAC_W - lps_pkg::OUT_W + 1;

	lps_pkg::lps_geom_t             geom_q;
	logic [lps_pkg::INV_W-1:0]      inv_q;
	logic                           en, push, pop, fits;
	logic                           head_valid_q, skid_valid_q;
	result_t                        head_q, skid_q, res;
	logic [HI_W-1:0]                hi_bits;

	logic signed [lps_pkg::S_W-1:0] sum_chain [lps_pkg::N_CELLS+1];
	logic signed [lps_pkg::P_W-1:0] acc_chain [lps_pkg::N_CELLS+1];
	lps_pkg::lps_tag_t              tag_chain [lps_pkg::N_CELLS+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.width         <= lps_pkg::WID_W'(lps_pkg::W_RST);
			geom_q.height        <= lps_pkg::HGT_W'(lps_pkg::H_RST);
			geom_q.right_margin  <= 2'(lps_pkg::MARGIN_RST);
			geom_q.bottom_margin <= 2'(lps_pkg::MARGIN_RST);
			inv_q                <= lps_pkg::INV_W'(lps_pkg::INV_RST);
		end else if (cfg_valid) begin
			case (lps_pkg::lps_reg_t'(cfg_index))
				lps_pkg::REG_GRID_WIDTH: begin
					if (32'(cfg_data[lps_pkg::GW_FIELD_W-1:0]) < 32'(lps_pkg::MIN_DIM)) begin
						geom_q.width <= lps_pkg::WID_W'(lps_pkg::MIN_DIM);
					end else if (32'(cfg_data[lps_pkg::GW_FIELD_W-1:0])
						> 32'(lps_pkg::MAX_WIDTH)) begin
						geom_q.width <= lps_pkg::WID_W'(lps_pkg::MAX_WIDTH);
					end else begin
						geom_q.width <= lps_pkg::WID_W'(cfg_data[lps_pkg::GW_FIELD_W-1:0]);
					end
				end
				lps_pkg::REG_GRID_HEIGHT: begin
					if (32'(cfg_data[lps_pkg::GH_FIELD_W-1:0]) < 32'(lps_pkg::MIN_DIM)) begin
						geom_q.height <= lps_pkg::HGT_W'(lps_pkg::MIN_DIM);
					end else if (32'(cfg_data[lps_pkg::GH_FIELD_W-1:0])
						> 32'(lps_pkg::MAX_HEIGHT)) begin
						geom_q.height <= lps_pkg::HGT_W'(lps_pkg::MAX_HEIGHT);
					end else begin
						geom_q.height <= cfg_data[lps_pkg::GH_FIELD_W-1:0];
					end
				end
				lps_pkg::REG_RIGHT_MARGIN: begin
					if (32'(cfg_data[lps_pkg::MG_FIELD_W-1:0]) < 32'(lps_pkg::MARGIN_MIN)) begin
						geom_q.right_margin <= 2'(lps_pkg::MARGIN_MIN);
					end else if (32'(cfg_data[lps_pkg::MG_FIELD_W-1:0])
						> 32'(lps_pkg::MARGIN_MAX)) begin
						geom_q.right_margin <= 2'(lps_pkg::MARGIN_MAX);
					end else begin
						geom_q.right_margin <= cfg_data[lps_pkg::MG_FIELD_W-1:0];
					end
				end
				lps_pkg::REG_BOTTOM_MARGIN: begin
					if (32'(cfg_data[lps_pkg::MG_FIELD_W-1:0]) < 32'(lps_pkg::MARGIN_MIN)) begin
						geom_q.bottom_margin <= 2'(lps_pkg::MARGIN_MIN);
					end else if (32'(cfg_data[lps_pkg::MG_FIELD_W-1:0])
						> 32'(lps_pkg::MARGIN_MAX)) begin
						geom_q.bottom_margin <= 2'(lps_pkg::MARGIN_MAX);
					end else begin
						geom_q.bottom_margin <= cfg_data[lps_pkg::MG_FIELD_W-1:0];
					end
				end
				lps_pkg::REG_INV_H_SQ: begin
					inv_q <= cfg_data[lps_pkg::INV_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign en            = ~(head_valid_q & skid_valid_q);
	assign s_axis_tready = en;

	lps_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_axis_tvalid),
		.sample     (lps_pkg::SAMPLE_BITS'(s_axis_tdata)),
		.grid_start (s_axis_tuser),
		.geom       (geom_q),
		.sum_s2     (sum_chain[0]),
		.tag_s2     (tag_chain[0])
	);

	assign acc_chain[0] = '0;

	for (genvar k = 0; k < lps_pkg::N_CELLS; k++) begin : g_cell
		lps_mac_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.digit   (inv_q[lps_pkg::INV_W-1-k*lps_pkg::DIG_W -: lps_pkg::DIG_W]),
			.sum_in  (sum_chain[k]),
			.acc_in  (acc_chain[k]),
			.tag_in  (tag_chain[k]),
			.sum_out (sum_chain[k+1]),
			.acc_out (acc_chain[k+1]),
			.tag_out (tag_chain[k+1])
		);
	end

	// drop the fraction with floor, then clip to the output range
	always_comb begin
		hi_bits = acc_chain[lps_pkg::N_CELLS][lps_pkg::P_W-1 -: HI_W];
		fits    = (&hi_bits) | ~(|hi_bits);
		res.col = tag_chain[lps_pkg::N_CELLS].col;
		res.row = tag_chain[lps_pkg::N_CELLS].row;
		res.saturated = ~fits;
		if (fits) begin
			res.value = acc_chain[lps_pkg::N_CELLS][lps_pkg::FRAC_W +: lps_pkg::OUT_W];
		end else if (acc_chain[lps_pkg::N_CELLS][lps_pkg::P_W-1]) begin
			res.value = {1'b1, {(lps_pkg::OUT_W-1){1'b0}}};
		end else begin
			res.value = {1'b0, {(lps_pkg::OUT_W-1){1'b1}}};
		end
	end

	assign push = en & tag_chain[lps_pkg::N_CELLS].valid;
	assign pop  = head_valid_q & m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				head_valid_q <= 1'b1;
				skid_valid_q <= push;
			end else begin
				head_valid_q <= push;
			end
		end else if (push) begin
			if (head_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				head_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				head_q <= skid_q;
				if (push) begin
					skid_q <= res;
				end
			end else if (push) begin
				head_q <= res;
			end
		end else if (push) begin
			if (head_valid_q) begin
				skid_q <= res;
			end else begin
				head_q <= res;
			end
		end
	end

	assign m_axis_tvalid = head_valid_q;
	assign m_axis_tdata  = lps_pkg::OUT_TDATA_W'({head_q.value, head_q.row, head_q.col});
	assign m_axis_tuser  = head_q.saturated;

endmodule

// File: sv/lps_checker.sv
module lps_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tready,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [lps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input logic                               m_axis_tuser
);

	localparam int ROW_LO = lps_pkg::COL_W;
	localparam int VAL_LO = lps_pkg::COL_W + lps_pkg::ROW_W;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result waiting");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			(m_axis_tdata[VAL_LO +: lps_pkg::OUT_W] == 32'h7FFF_FFFF)
			|| (m_axis_tdata[VAL_LO +: lps_pkg::OUT_W] == 32'h8000_0000))
		else $error("saturated result not at a range limit");

	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[lps_pkg::COL_W-1:0] != '0)
			&& (m_axis_tdata[ROW_LO +: lps_pkg::ROW_W] != '0))
		else $error("result for a boundary cell");

endmodule

bind five_point_laplacian_stencil lps_checker u_lps_checker (.*);

// File: tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int TAIL_CYCLES   = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_ITEMS  = 400;
	localparam int IDLE_PCT      = 33;
	localparam int REPORT_LIMIT  = 10;

	localparam logic signed [71:0] LAP_MAX = 72'sd2147483647;
	localparam logic signed [71:0] LAP_MIN = -72'sd2147483648;
	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;

	typedef enum int {
		FILL_WIDE,
		FILL_NARROW,
		FILL_EXTREME
	} fill_t;

	typedef struct {
		logic [31:0] sample;
		logic        grid_start;
	} grid_item_t;

	typedef struct packed {
		logic [lps_pkg::COL_W-1:0] col;
		logic [lps_pkg::ROW_W-1:0] row;
		logic [lps_pkg::OUT_W-1:0] value;
		logic                      sat;
	} stencil_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [lps_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [lps_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [lps_pkg::CFG_IDX_W-1:0] cfg_index = lps_pkg::REG_GRID_WIDTH;
	logic [lps_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	grid_item_t sample_q[$];
	stencil_result_t laplacian_q[$];

	logic [lps_pkg::GW_FIELD_W-1:0] reg_width = 11'd1024;
	logic [lps_pkg::GH_FIELD_W-1:0] reg_height = 13'd1024;
	logic [lps_pkg::MG_FIELD_W-1:0] reg_rmargin = 2'd1;
	logic [lps_pkg::MG_FIELD_W-1:0] reg_bmargin = 2'd1;
	logic [lps_pkg::INV_W-1:0] reg_inv = 32'd65536;

	logic signed [31:0] above_row[lps_pkg::MAX_WIDTH];
	logic signed [31:0] centre_row[lps_pkg::MAX_WIDTH];
	bit above_ok[lps_pkg::MAX_WIDTH];
	bit centre_ok[lps_pkg::MAX_WIDTH];
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;

	bit s_taken = 1'b0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int mismatches = 0;
	int cycle_count = 0;

	stencil_result_t seen;
	stencil_result_t want;

	int random_items;
	int phase_no;
	int n_items;
	int w_eff;
	int h_eff;
	bit fresh;
	logic [lps_pkg::GW_FIELD_W-1:0] gw;
	logic [lps_pkg::GH_FIELD_W-1:0] gh;
	logic [lps_pkg::MG_FIELD_W-1:0] rm;
	logic [lps_pkg::MG_FIELD_W-1:0] bm;
	logic [lps_pkg::INV_W-1:0] inv;

	five_point_laplacian_stencil u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic bit stores_cover(int unsigned w);
		for (int i = 0; i < w; i++) begin
			if (!above_ok[i] || !centre_ok[i]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [31:0] pick_sample(fill_t mode);
		int narrow;
		narrow = int'($urandom_range(0, 8191)) - 4096;
		case (mode)
			FILL_NARROW: return narrow * 4096;
			FILL_EXTREME: begin
				case ($urandom_range(0, 3))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return 32'h0;
					default: return $urandom();
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	task automatic predict_laplacian(logic [31:0] raw, logic start);
		int unsigned w, h, rmg, bmg, c, r;
		longint up, left, right, mid, down, acc;
		logic signed [71:0] acc_ext, inv_ext, scaled;
		stencil_result_t res;
		w = clamp_u(32'(reg_width), lps_pkg::MIN_DIM, lps_pkg::MAX_WIDTH);
		h = clamp_u(32'(reg_height), lps_pkg::MIN_DIM, lps_pkg::MAX_HEIGHT);
		rmg = clamp_u(32'(reg_rmargin), lps_pkg::MARGIN_MIN, lps_pkg::MARGIN_MAX);
		bmg = clamp_u(32'(reg_bmargin), lps_pkg::MARGIN_MIN, lps_pkg::MARGIN_MAX);
		down = longint'($signed(raw));
		if (start) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= w) col_pos = 0;
		if (row_pos >= h) row_pos = 0;
		c = col_pos;
		r = row_pos;
		if (r >= 2 && c >= 1 && c + rmg <= w - 1 && r - 1 + bmg <= h - 1) begin
			up = above_row[c];
			left = above_row[c-1];
			right = centre_row[c+1];
			mid = centre_row[c];
			acc = up + down + left + right - lps_pkg::CENTRE_GAIN * mid;
			acc_ext = acc;
			inv_ext = {40'd0, reg_inv};
			scaled = (acc_ext * inv_ext) >>> lps_pkg::FRAC_W;
			res.col = c[lps_pkg::COL_W-1:0];
			res.row = lps_pkg::ROW_W'(r - 1);
			if (scaled > LAP_MAX) begin
				res.value = Q_MAX;
				res.sat = 1'b1;
			end else if (scaled < LAP_MIN) begin
				res.value = Q_MIN;
				res.sat = 1'b1;
			end else begin
				res.value = scaled[lps_pkg::OUT_W-1:0];
				res.sat = 1'b0;
			end
			laplacian_q.push_back(res);
		end
		above_row[c] = centre_row[c];
		above_ok[c] = centre_ok[c];
		centre_row[c] = raw;
		centre_ok[c] = 1'b1;
		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h) row_pos = 0;
		end
	endtask

	task automatic write_reg(lps_pkg::lps_reg_t idx, logic [lps_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			lps_pkg::REG_GRID_WIDTH: reg_width = val[lps_pkg::GW_FIELD_W-1:0];
			lps_pkg::REG_GRID_HEIGHT: reg_height = val[lps_pkg::GH_FIELD_W-1:0];
			lps_pkg::REG_RIGHT_MARGIN: reg_rmargin = val[lps_pkg::MG_FIELD_W-1:0];
			lps_pkg::REG_BOTTOM_MARGIN: reg_bmargin = val[lps_pkg::MG_FIELD_W-1:0];
			lps_pkg::REG_INV_H_SQ: reg_inv = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(logic [lps_pkg::GW_FIELD_W-1:0] w,
			logic [lps_pkg::GH_FIELD_W-1:0] h, logic [lps_pkg::MG_FIELD_W-1:0] rmg,
			logic [lps_pkg::MG_FIELD_W-1:0] bmg, logic [lps_pkg::INV_W-1:0] scale);
		write_reg(lps_pkg::REG_GRID_WIDTH, ($urandom() << lps_pkg::GW_FIELD_W) | 32'(w));
		write_reg(lps_pkg::REG_GRID_HEIGHT, ($urandom() << lps_pkg::GH_FIELD_W) | 32'(h));
		write_reg(lps_pkg::REG_RIGHT_MARGIN, ($urandom() << lps_pkg::MG_FIELD_W) | 32'(rmg));
		write_reg(lps_pkg::REG_BOTTOM_MARGIN, ($urandom() << lps_pkg::MG_FIELD_W) | 32'(bmg));
		write_reg(lps_pkg::REG_INV_H_SQ, scale);
	endtask

	task automatic wait_idle();
		while (sample_q.size() != 0 || laplacian_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_item(logic [31:0] sample, logic start);
		grid_item_t it;
		it.sample = sample;
		it.grid_start = start;
		sample_q.push_back(it);
	endtask

	// 3x3 grid: only the centre cell is interior
	task automatic push_grid3(logic [31:0] up, logic [31:0] left, logic [31:0] mid,
			logic [31:0] right, logic [31:0] down, logic start);
		push_item(32'h0, start);
		push_item(up, 1'b0);
		push_item(32'h0, 1'b0);
		push_item(left, 1'b0);
		push_item(mid, 1'b0);
		push_item(right, 1'b0);
		push_item(32'h0, 1'b0);
		push_item(down, 1'b0);
		push_item(32'h0, 1'b0);
	endtask

	task automatic run_phase(int n, fill_t mode, bit start, int noise_pct);
		for (int i = 0; i < n; i++) begin
			push_item(pick_sample(mode),
				(i == 0) ? start : ($urandom_range(0, 99) < noise_pct));
		end
		wait_idle();
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_taken) begin
			if (sample_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= sample_q[0].sample;
				s_axis_tuser <= sample_q[0].grid_start;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		s_taken = arst_n && s_axis_tvalid && s_axis_tready;
		if (s_taken) begin
			predict_laplacian(s_axis_tdata, s_axis_tuser);
			void'(sample_q.pop_front());
		end
	end

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.col = m_axis_tdata[lps_pkg::COL_W-1:0];
			seen.row = m_axis_tdata[lps_pkg::COL_W +: lps_pkg::ROW_W];
			seen.value = m_axis_tdata[lps_pkg::COL_W+lps_pkg::ROW_W +: lps_pkg::OUT_W];
			seen.sat = m_axis_tuser;
			if (laplacian_q.size() == 0) begin
				if (mismatches < REPORT_LIMIT)
					$display("unexpected item: col %0d row %0d value %h sat %0b",
						seen.col, seen.row, seen.value, seen.sat);
				mismatches++;
			end else begin
				want = laplacian_q.pop_front();
				if (seen.col != want.col || seen.row != want.row ||
						seen.value != want.value || seen.sat != want.sat) begin
					if (mismatches < REPORT_LIMIT) begin
						$display("mismatch: expected col %0d row %0d value %h sat %0b",
							want.col, want.row, want.value, want.sat);
						$display("          got      col %0d row %0d value %h sat %0b",
							seen.col, seen.row, seen.value, seen.sat);
					end
					mismatches++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		configure(11'd3, 13'd3, 2'd1, 2'd1, 32'd65536);
		push_grid3(Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MAX, 1'b1);
		// row counter wraps into the next grid without a start flag
		push_grid3(Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MIN, 1'b0);
		wait_idle();

		// negative sum with tiny scale: floor toward minus infinity
		write_reg(lps_pkg::REG_INV_H_SQ, 32'd1);
		push_grid3(32'd1, 32'd0, 32'd1, 32'd0, 32'd0, 1'b1);
		wait_idle();

		// widest grid, out-of-range width and height clamp to their maxima
		calm = 1'b1;
		configure(11'd2047, 13'd8191, 2'd2, 2'd2, $urandom());
		run_phase(lps_pkg::MAX_WIDTH + $urandom_range(60, 120), FILL_WIDE, 1'b1, 0);
		calm = 1'b0;

		random_items = 0;
		phase_no = 0;
		while (random_items < RANDOM_ITEMS) begin
			gw = lps_pkg::GW_FIELD_W'(($urandom_range(0, 7) == 0) ?
				$urandom_range(0, 2) : $urandom_range(3, 12));
			case ($urandom_range(0, 9))
				0: gh = lps_pkg::GH_FIELD_W'($urandom_range(0, 2));
				1: gh = ($urandom_range(0, 1) == 0) ? 13'd8191 : 13'd4096;
				default: gh = lps_pkg::GH_FIELD_W'($urandom_range(3, 10));
			endcase
			rm = lps_pkg::MG_FIELD_W'($urandom_range(0, 3));
			bm = lps_pkg::MG_FIELD_W'($urandom_range(0, 3));
			if (phase_no == 1) begin
				rm = 2'd1;
				bm = 2'd1;
			end
			case ($urandom_range(0, 5))
				0: inv = 32'd65536;
				1: inv = 32'd0;
				2: inv = 32'hFFFF_FFFF;
				3: inv = $urandom_range(1, 255);
				4: inv = $urandom_range(0, 32'h3FFFF);
				default: inv = $urandom();
			endcase
			configure(gw, gh, rm, bm, inv);
			w_eff = int'(clamp_u(32'(gw), lps_pkg::MIN_DIM, lps_pkg::MAX_WIDTH));
			h_eff = int'(clamp_u(32'(gh), lps_pkg::MIN_DIM, lps_pkg::MAX_HEIGHT));
			fresh = !(stores_cover(w_eff) && $urandom_range(0, 2) == 0);
			if (h_eff > 16)
				n_items = w_eff * $urandom_range(3, 8);
			else
				n_items = w_eff * h_eff * $urandom_range(1, 3) + $urandom_range(0, 5);
			if (phase_no == 1) begin
				if (n_items < 80) n_items = 80;
				hold_req = 1'b1;
			end
			calm = (phase_no == 6);
			run_phase(n_items, fill_t'($urandom_range(0, 2)), fresh,
				($urandom_range(0, 3) == 0) ? 3 : 0);
			calm = 1'b0;
			random_items += n_items;
			phase_no++;
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && laplacian_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: filelist.f
sv/lps_pkg.sv
sv/lps_window.sv
sv/lps_mac_cell.sv
sv/five_point_laplacian_stencil.sv
sv/lps_checker.sv
tb/sv/tb.sv
